// ===== rtl/mec_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the mandelbrot escape counter
// no dependencies

package mec_pkg;

	localparam int COORD_W = 32;
	localparam int CNT_W = 16;
	localparam int CFG_W = 16;
	localparam int LIMB_W = 32;

	localparam int FRAC_BITS_DEF = 28;
	localparam int COUNT_BITS_DEF = 16;

	localparam logic [CFG_W-1:0] MAX_ITER_RST = 16'd256;

	localparam int TAG_W = 2;
	localparam logic [TAG_W-1:0] TAG_XX = 2'd0;
	localparam logic [TAG_W-1:0] TAG_YY = 2'd1;
	localparam logic [TAG_W-1:0] TAG_XY = 2'd2;
	localparam logic [TAG_W-1:0] TAG_NONE = 2'd3;

	typedef struct packed {
		logic start;
		logic [TAG_W-1:0] tag;
	} mul_req_t;

	typedef struct packed {
		logic done;
		logic [TAG_W-1:0] tag;
	} mul_rsp_t;

endpackage

// ===== rtl/mec_mul.sv =====
`timescale 1ns / 1ps
// shared signed fixed-point multiplier, one limb product per cycle
// magnitude product truncated to FRAC_BITS fraction bits, then signed
// depends on mec_pkg

module mec_mul #(
	parameter int FRAC_BITS = mec_pkg::FRAC_BITS_DEF,
	parameter int OP_W = 32,
	parameter int PROD_W = 35
) (
	input  logic clk,
	input  logic arst_n,
	input  mec_pkg::mul_req_t req,
	input  logic signed [OP_W-1:0] a,
	input  logic signed [OP_W-1:0] b,
	output logic ready,
	output mec_pkg::mul_rsp_t rsp,
	output logic signed [PROD_W-1:0] res
);

	localparam int LW_BITS = mec_pkg::LIMB_W;
	localparam int NL = (OP_W + LW_BITS - 1) / LW_BITS;
	localparam int AW = NL * LW_BITS;
	localparam int ACC_W = 2 * AW;
	localparam int PPW = 2 * LW_BITS;
	localparam int LW = (NL > 1) ? $clog2(NL) : 1;

	logic [OP_W-1:0] a_u, b_u, abs_a, abs_b;
	logic [AW-1:0] mag_a_q, mag_b_q;
	logic neg_q;
	logic [mec_pkg::TAG_W-1:0] tag_q;
	logic act_q;
	logic [LW-1:0] ia_q, ib_q;
	logic last;
	logic [LW_BITS-1:0] limb_a, limb_b;

	logic v_s1, first_s1, last_s1, neg_s1;
	logic [PPW-1:0] pp_s1;
	logic [LW:0] sh_s1;
	logic [mec_pkg::TAG_W-1:0] tag_s1;

	logic v_s2, neg_s2;
	logic [mec_pkg::TAG_W-1:0] tag_s2;
	logic [ACC_W-1:0] acc_q, acc_base, acc_shr;
	logic [PROD_W-1:0] mag;

	assign a_u = a;
	assign b_u = b;
	assign abs_a = a_u[OP_W-1] ? (~a_u + OP_W'(1)) : a_u;
	assign abs_b = b_u[OP_W-1] ? (~b_u + OP_W'(1)) : b_u;

	assign last = (ia_q == LW'(NL - 1)) && (ib_q == LW'(NL - 1));
	assign ready = !act_q || last;

	assign limb_a = mag_a_q[ia_q * LW_BITS +: LW_BITS];
	assign limb_b = mag_b_q[ib_q * LW_BITS +: LW_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			ia_q <= '0;
			ib_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (req.start && ready) begin
				act_q <= 1'b1;
				ia_q <= '0;
				ib_q <= '0;
			end else if (act_q) begin
				if (last) begin
					act_q <= 1'b0;
				end else if (ib_q == LW'(NL - 1)) begin
					ib_q <= '0;
					ia_q <= ia_q + LW'(1);
				end else begin
					ib_q <= ib_q + LW'(1);
				end
			end
			v_s1 <= act_q;
			v_s2 <= v_s1 && last_s1;
		end
	end

	// operand capture and limb products
	always_ff @(posedge clk) begin
		if (req.start && ready) begin
			mag_a_q <= AW'(abs_a);
			mag_b_q <= AW'(abs_b);
			neg_q <= a_u[OP_W-1] ^ b_u[OP_W-1];
			tag_q <= req.tag;
		end
		if (act_q) begin
			pp_s1 <= PPW'(limb_a) * PPW'(limb_b);
			sh_s1 <= (LW + 1)'(ia_q) + (LW + 1)'(ib_q);
			first_s1 <= (ia_q == '0) && (ib_q == '0);
			last_s1 <= last;
			neg_s1 <= neg_q;
			tag_s1 <= tag_q;
		end
	end

	assign acc_base = first_s1 ? '0 : acc_q;

	// accumulation of shifted limb products
	always_ff @(posedge clk) begin
		if (v_s1) begin
			acc_q <= acc_base + (ACC_W'(pp_s1) << (sh_s1 * LW_BITS));
			if (last_s1) begin
				neg_s2 <= neg_s1;
				tag_s2 <= tag_s1;
			end
		end
	end

	assign acc_shr = acc_q >> FRAC_BITS;
	assign mag = acc_shr[PROD_W-1:0];
	assign res = neg_s2 ? (~mag + PROD_W'(1)) : mag;

	assign rsp.done = v_s2;
	assign rsp.tag = tag_s2;

endmodule

// ===== rtl/mandelbrot_escape_count_top.sv =====
`timescale 1ns / 1ps
// mandelbrot escape counter: sequencer, point registers and result register
// instantiates mec_mul, depends on mec_pkg
//
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   c_real, c_imag
// out       output     out_valid / out_stall remaining_count
// cfg       input      cfg_valid / cfg_ready cfg_data (max_iterations)
//
// one pass (x*x, y*y, x*y through the single shared multiplier, then the
// escape test and update) runs each multiply as S limb products, S = 1
// up to FRAC_BITS 28; in_stall is high from accept until the result
// enters the output register
// the output register holds a result under out_stall while a new point runs
// max_iterations resets to 256

module mandelbrot_escape_count_top #(
	parameter int FRAC_BITS = mec_pkg::FRAC_BITS_DEF,
	parameter int COUNT_BITS = mec_pkg::COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [mec_pkg::COORD_W-1:0] c_real,
	input  logic signed [mec_pkg::COORD_W-1:0] c_imag,
	output logic out_valid,
	input  logic out_stall,
	output logic [mec_pkg::CNT_W-1:0] remaining_count,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [mec_pkg::CFG_W-1:0] cfg_data
);

	localparam int XW = (FRAC_BITS + 4 > mec_pkg::COORD_W) ? FRAC_BITS + 4 : mec_pkg::COORD_W;
	localparam int PW = ((62 - FRAC_BITS > FRAC_BITS + 6) ? 62 - FRAC_BITS : FRAC_BITS + 6) + 2;
	localparam int SUM_W = PW + 2;
	localparam int CW = COUNT_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN = 2'd1;
	localparam logic [1:0] ST_DEC = 2'd2;
	localparam logic [1:0] ST_HOLD = 2'd3;

	localparam logic signed [SUM_W-1:0] FOUR = SUM_W'(4) << FRAC_BITS;

	logic [1:0] state_q;
	logic [mec_pkg::TAG_W-1:0] issue_q;
	logic [mec_pkg::CFG_W-1:0] max_q;
	logic out_valid_q;
	logic [mec_pkg::CNT_W-1:0] out_cnt_q;

	logic signed [XW-1:0] cx_q, cy_q, x_q, y_q;
	logic signed [PW-1:0] x2_q, y2_q, xy_q;
	logic [CW-1:0] cnt_q, cnt_start;
	logic [31:0] max_ext, cnt_ext;

	logic in_acc, slot_free, go_on, load_out;
	logic signed [SUM_W-1:0] mag2, x_nxt, y_nxt;

	mec_pkg::mul_req_t mul_req;
	mec_pkg::mul_rsp_t mul_rsp;
	logic mul_ready;
	logic signed [XW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] mul_res;

	mec_mul #(
		.FRAC_BITS(FRAC_BITS),
		.OP_W(XW),
		.PROD_W(PW)
	) u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.req(mul_req),
		.a(mul_a),
		.b(mul_b),
		.ready(mul_ready),
		.rsp(mul_rsp),
		.res(mul_res)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign remaining_count = out_cnt_q;

	assign max_ext = 32'(max_q);
	assign cnt_start = (max_ext[CW-1:0] == '0) ? CW'(1) : max_ext[CW-1:0];
	assign cnt_ext = 32'(cnt_q);

	assign mul_req.start = (state_q == ST_RUN) && (issue_q != mec_pkg::TAG_NONE);
	assign mul_req.tag = issue_q;

	always_comb begin
		case (issue_q)
			mec_pkg::TAG_XX: begin
				mul_a = x_q;
				mul_b = x_q;
			end
			mec_pkg::TAG_YY: begin
				mul_a = y_q;
				mul_b = y_q;
			end
			default: begin
				mul_a = x_q;
				mul_b = y_q;
			end
		endcase
	end

	// escape test and next point
	assign mag2 = SUM_W'(x2_q) + SUM_W'(y2_q);
	assign x_nxt = SUM_W'(x2_q) - SUM_W'(y2_q) + SUM_W'(cx_q);
	assign y_nxt = (SUM_W'(xy_q) <<< 1) + SUM_W'(cy_q);
	assign go_on = (mag2 < FOUR) && (cnt_q > CW'(1));

	assign slot_free = !out_valid_q || !out_stall;
	assign load_out = (((state_q == ST_DEC) && !go_on) || (state_q == ST_HOLD)) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issue_q <= mec_pkg::TAG_NONE;
			max_q <= mec_pkg::MAX_ITER_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (mul_req.start && mul_ready) begin
				issue_q <= issue_q + mec_pkg::TAG_W'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_RUN;
						issue_q <= mec_pkg::TAG_XX;
					end
				end
				ST_RUN: begin
					if (mul_rsp.done && (mul_rsp.tag == mec_pkg::TAG_XY)) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					if (go_on) begin
						state_q <= ST_RUN;
						issue_q <= mec_pkg::TAG_XX;
					end else if (slot_free) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cx_q <= XW'(c_real);
			cy_q <= XW'(c_imag);
			x_q <= XW'(c_real);
			y_q <= XW'(c_imag);
			cnt_q <= cnt_start;
		end
		if (mul_rsp.done) begin
			case (mul_rsp.tag)
				mec_pkg::TAG_XX: x2_q <= mul_res;
				mec_pkg::TAG_YY: y2_q <= mul_res;
				default: xy_q <= mul_res;
			endcase
		end
		if ((state_q == ST_DEC) && go_on) begin
			x_q <= x_nxt[XW-1:0];
			y_q <= y_nxt[XW-1:0];
			cnt_q <= cnt_q - CW'(1);
		end
		if (load_out) begin
			out_cnt_q <= cnt_ext[mec_pkg::CNT_W-1:0];
		end
	end

	a_accept_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_RUN))
		else $error("accepted request did not start a run");

	a_mul_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == ST_RUN))
		else $error("multiplier result outside a run");

	a_dec_after_xy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEC) |-> $past(mul_rsp.done && (mul_rsp.tag == mec_pkg::TAG_XY)))
		else $error("escape test without fresh cross product");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (remaining_count != '0))
		else $error("remaining count of zero");

endmodule

// ===== verif/tb_mandelbrot_escape_count_top.sv =====
`timescale 1ns / 1ps
// testbench for mandelbrot_escape_count_top: directed points, then random points in
// phases of max_iterations, each count checked against a known count or an escape-time predictor
// depends on mec_pkg and the rtl of mandelbrot_escape_count_top

module tb_mandelbrot_escape_count_top;

	localparam int FRAC = mec_pkg::FRAC_BITS_DEF;
	localparam logic [63:0] MAG_CLAMP = 64'd1 << 61;
	localparam int CYCLE_LIMIT = 10_000_000;
	localparam int PHASES = 15;
	localparam int PHASE_POINTS = 50;
	localparam logic signed [31:0] ONE = 32'sh1000_0000;
	localparam logic signed [31:0] TWO = 32'sh2000_0000;

	typedef struct packed {
		logic cfg_write;
		logic [mec_pkg::CFG_W-1:0] cfg_value;
		logic signed [mec_pkg::COORD_W-1:0] re;
		logic signed [mec_pkg::COORD_W-1:0] im;
		logic has_known;
		logic [mec_pkg::CNT_W-1:0] known_count;
	} point_row_t;

	localparam int NUM_ROWS = 23;
	localparam point_row_t DIRECTED [0:NUM_ROWS-1] = '{
		'{1'b0, 16'd0, 32'sd0, 32'sd0, 1'b1, 16'd1},
		'{1'b0, 16'd0, TWO, 32'sd0, 1'b1, 16'd256},
		'{1'b0, 16'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 16'd256},
		'{1'b0, 16'd0, 32'sh8000_0000, 32'sh8000_0000, 1'b1, 16'd256},
		'{1'b0, 16'd0, 32'sh8000_0000, 32'sd0, 1'b1, 16'd256},
		'{1'b0, 16'd0, 32'sd0, 32'sh7FFF_FFFF, 1'b1, 16'd256},
		'{1'b0, 16'd0, -TWO, 32'sd0, 1'b1, 16'd256},
		'{1'b0, 16'd0, 32'sd0, TWO, 1'b1, 16'd256},
		'{1'b0, 16'd0, -ONE, 32'sd0, 1'b1, 16'd1},
		'{1'b0, 16'd0, 32'sh1FFF_FFFF, 32'sd0, 1'b0, 16'd0},
		'{1'b0, 16'd0, 32'sh0400_0000, 32'sd0, 1'b0, 16'd0},
		'{1'b0, 16'd0, -32'sh0C00_0000, 32'sh0199_9999, 1'b0, 16'd0},
		'{1'b0, 16'd0, 32'sh0800_0000, 32'sh0800_0000, 1'b0, 16'd0},
		'{1'b0, 16'd0, ONE, ONE, 1'b0, 16'd0},
		'{1'b0, 16'd0, -32'sd1, -32'sd1, 1'b0, 16'd0},
		'{1'b0, 16'd0, 32'sd0, -ONE, 1'b0, 16'd0},
		'{1'b1, 16'd0, 32'sd0, 32'sd0, 1'b1, 16'd1},
		'{1'b0, 16'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 16'd1},
		'{1'b1, 16'd1, -32'sh0600_0000, 32'sd0, 1'b1, 16'd1},
		'{1'b1, 16'hFFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 16'hFFFF},
		'{1'b0, 16'd0, 32'sh8000_0000, 32'sd0, 1'b1, 16'hFFFF},
		'{1'b0, 16'd0, 32'sd0, 32'sd0, 1'b1, 16'd1},
		'{1'b1, 16'd2, 32'sh0800_0000, 32'sd0, 1'b0, 16'd0}
	};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [mec_pkg::COORD_W-1:0] c_real;
	logic signed [mec_pkg::COORD_W-1:0] c_imag;
	logic out_valid;
	logic out_stall;
	logic [mec_pkg::CNT_W-1:0] remaining_count;
	logic cfg_valid;
	logic cfg_ready;
	logic [mec_pkg::CFG_W-1:0] cfg_data;

	logic [mec_pkg::CFG_W-1:0] iter_limit;
	logic [mec_pkg::CNT_W-1:0] pending_counts [$];
	int mismatch_count;
	int cycles;
	bit no_idle;

	mandelbrot_escape_count_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.c_real(c_real),
		.c_imag(c_imag),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.remaining_count(remaining_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// exact product, magnitude truncated to FRAC fraction bits and clamped to MAG_CLAMP
	function automatic longint fixed_mul(input longint a, input longint b);
		logic neg;
		logic [63:0] ua;
		logic [63:0] ub;
		logic [127:0] prod;
		logic [63:0] mag;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? 64'(-a) : 64'(a);
		ub = (b < 0) ? 64'(-b) : 64'(b);
		prod = {64'd0, ua} * {64'd0, ub};
		if ((prod >> (64 + FRAC)) != 0)
			mag = MAG_CLAMP;
		else
			mag = 64'(prod >> FRAC);
		if (mag > MAG_CLAMP)
			mag = MAG_CLAMP;
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic logic [mec_pkg::CNT_W-1:0] escape_count(
		input logic signed [mec_pkg::COORD_W-1:0] re,
		input logic signed [mec_pkg::COORD_W-1:0] im,
		input logic [mec_pkg::CFG_W-1:0] limit);
		longint four;
		longint cx;
		longint cy;
		longint x;
		longint y;
		longint x2;
		longint y2;
		longint xy;
		int count;
		four = longint'(4) <<< FRAC;
		cx = longint'(re);
		cy = longint'(im);
		x = cx;
		y = cy;
		x2 = fixed_mul(x, x);
		y2 = fixed_mul(y, y);
		count = int'(limit);
		if (count == 0)
			count = 1;
		while (x2 + y2 < four && count > 1) begin
			xy = fixed_mul(x, y);
			y = xy + xy + cy;
			x = x2 - y2 + cx;
			x2 = fixed_mul(x, x);
			y2 = fixed_mul(y, y);
			count--;
		end
		return mec_pkg::CNT_W'(count);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic send_point(input logic signed [mec_pkg::COORD_W-1:0] re,
		input logic signed [mec_pkg::COORD_W-1:0] im, input logic has_known,
		input logic [mec_pkg::CNT_W-1:0] known_count);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 16);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		c_real <= re;
		c_imag <= im;
		do @(posedge clk); while (in_stall);
		pending_counts.push_back(has_known ? known_count : escape_count(re, im, iter_limit));
	endtask

	// lower the request and wait until every count is back
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_counts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [mec_pkg::CFG_W-1:0] value);
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		iter_limit = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// result side
	initial begin
		int gap;
		logic [mec_pkg::CNT_W-1:0] want;
		@(posedge arst_n);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 16);
			@(negedge clk);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			if (pending_counts.size() == 0) begin
				report_mismatch($sformatf("unexpected count %0d", remaining_count));
			end else begin
				want = pending_counts.pop_front();
				if (remaining_count !== want)
					report_mismatch($sformatf("remaining_count %0d, expected %0d",
						remaining_count, want));
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		logic signed [mec_pkg::COORD_W-1:0] re;
		logic signed [mec_pkg::COORD_W-1:0] im;
		logic [mec_pkg::CFG_W-1:0] limit;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		c_real = '0;
		c_imag = '0;
		out_stall = 1'b1;
		cfg_valid = 1'b0;
		cfg_data = '0;
		mismatch_count = 0;
		no_idle = 1'b0;
		iter_limit = mec_pkg::MAX_ITER_RST;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NUM_ROWS; i++) begin
			if (DIRECTED[i].cfg_write)
				write_limit(DIRECTED[i].cfg_value);
			send_point(DIRECTED[i].re, DIRECTED[i].im, DIRECTED[i].has_known,
				DIRECTED[i].known_count);
		end

		for (int p = 0; p < PHASES; p++) begin
			case ($urandom_range(0, 7))
				0: limit = 16'd1;
				1: limit = 16'd2;
				default: limit = mec_pkg::CFG_W'($urandom_range(3, 300));
			endcase
			write_limit(limit);
			no_idle = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < PHASE_POINTS; k++) begin
				if ($urandom_range(0, 9) < 7) begin
					// region around the set: real -2.25..0.75, imag -1.5..1.5
					re = -32'sh2400_0000 + 32'($urandom_range(0, 32'h3000_0000));
					im = -32'sh1800_0000 + 32'($urandom_range(0, 32'h3000_0000));
				end else begin
					re = $urandom;
					im = $urandom;
				end
				send_point(re, im, 1'b0, '0);
			end
		end

		wait_idle();
		repeat (50) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
